// File: rtl/assert_macros.svh
// Assertion helpers used by the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond holds at every clock edge out of reset.
`define PDQ_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

// Check that cons holds in the same cycle as ante.
`define PDQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define PDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/pdq_pkg.sv
package pdq_pkg;

	localparam int CAPACITY   = 16;
	localparam int LEVEL_BITS = 3;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int CLIP_W     = 8;
	localparam int ORDER_W    = 32;
	localparam int CTR_W      = 32;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [1:0] {
		PS_ACCEPT = 2'd0,
		PS_DUP    = 2'd1,
		PS_FULL   = 2'd2,
		PS_NONE   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic              op;
		logic [CLIP_W-1:0] clip_id;
		logic [2:0]        level;
		logic              player_busy;
	} item_t;

	typedef struct packed {
		logic              play_valid;
		logic [CLIP_W-1:0] play_clip;
		status_t           push_status;
		logic [4:0]        queue_level;
		logic              playing;
		logic [CTR_W-1:0]  full_drops;
		logic [CTR_W-1:0]  dup_drops;
	} result_t;

	typedef struct packed {
		logic [CLIP_W-1:0]     clip;
		logic [LEVEL_BITS-1:0] level;
		logic [ORDER_W-1:0]    order;
	} entry_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

endpackage

// File: rtl/pdq_cell.sv
module pdq_cell (
	input  logic              clk,
	input  pdq_pkg::cell_ctl_t ctl,
	input  pdq_pkg::entry_t   nbr,
	input  pdq_pkg::entry_t   wdata,
	output pdq_pkg::entry_t   ent
);
	import pdq_pkg::*;

	entry_t ent_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			ent_q <= wdata;
		end else if (ctl.shift) begin
			ent_q <= nbr;
		end
	end

	assign ent = ent_q;

endmodule

// File: rtl/priority_dedup_dispatch_queue_unit.sv
// Priority dispatch queue of clip identifiers with duplicate suppression.
// Input: an item word on item is taken at a rising edge with start high and
// busy low. op selects push (store clip_id at level) or tick (update the
// playing flag from player_busy and dispatch the best waiting clip).
// Output: one result word per item on result, marked by done for exactly
// one cycle; the receiver cannot hold it off and needs no handshake back.
// Entries sit in a ring of CAPACITY cells that rotates one place a cycle
// while an item is worked; the head cell is checked for duplicates, the
// winner (highest level, then lowest order number) and the last entry.
// Timing: busy rises in the cycle after acceptance, the ring rotates once
// through all CAPACITY cells in ST_SCAN, ST_FIN commits, and done is
// registered from ST_FIN. busy is low in the done cycle; a new item is
// taken only once the previous one has been through the full turn of the
// cell ring and the commit.
// Reset (arst_n low) empties the queue, clears the playing flag, the order
// number and both drop counters; entry contents are not cleared.
module priority_dedup_dispatch_queue_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  pdq_pkg::item_t   item,
	output logic             done,
	output pdq_pkg::result_t result
);
	import pdq_pkg::*;

	`include "assert_macros.svh"

	state_t state_q, state_d;
	logic [IDX_W-1:0] cnt_q;
	item_t item_q;
	entry_t ent [CAPACITY];
	cell_ctl_t ctl [CAPACITY];
	entry_t wdata;
	logic [IDX_W-1:0] widx;
	logic wen;
	logic shift;

	logic [CNT_W-1:0] count_q, count_d;
	logic [ORDER_W-1:0] next_order_q, next_order_d;
	logic playing_q, playing_d;
	logic [CLIP_W-1:0] playing_clip_q, playing_clip_d;
	logic [CTR_W-1:0] full_drops_q, full_drops_d;
	logic [CTR_W-1:0] dup_drops_q, dup_drops_d;
	logic found_q;
	entry_t best_q, last_q;
	logic [IDX_W-1:0] best_idx_q;
	logic done_q;
	result_t result_q;

	entry_t head;
	logic head_valid, head_last, better, first;
	logic dup_hit, is_full, still_busy, dispatch, pv;
	logic [CLIP_W-1:0] pclip;
	status_t status;

	genvar k;
	generate
		for (k = 0; k < CAPACITY; k++) begin : g_cell
			assign ctl[k].shift = shift;
			assign ctl[k].load  = wen && (widx == IDX_W'(k));
			pdq_cell u_cell (
				.clk   (clk),
				.ctl   (ctl[k]),
				.nbr   (ent[(k + 1) % CAPACITY]),
				.wdata (wdata),
				.ent   (ent[k])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		shift   = 1'b0;
		busy    = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				shift = 1'b1;
				if (cnt_q == IDX_W'(CAPACITY - 1)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == ST_IDLE) begin
			cnt_q <= '0;
		end else if (state_q == ST_SCAN) begin
			cnt_q <= cnt_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			item_q <= item;
		end
	end

	// scan the head cell as the ring turns
	assign head       = ent[0];
	assign first      = (cnt_q == '0);
	assign head_valid = (CNT_W'(cnt_q) < count_q);
	assign head_last  = (CNT_W'(cnt_q) == count_q - CNT_W'(1));
	assign better     = (head.level > best_q.level) ||
		((head.level == best_q.level) && (head.order < best_q.order));

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			found_q <= (found_q && !first) ||
				(head_valid && (head.clip == item_q.clip_id));
			if (first || (head_valid && better)) begin
				best_q     <= head;
				best_idx_q <= cnt_q;
			end
			if (head_last) begin
				last_q <= head;
			end
		end
	end

	always_comb begin
		dup_hit    = found_q || (playing_q && (playing_clip_q == item_q.clip_id));
		is_full    = (count_q == CNT_W'(CAPACITY));
		still_busy = playing_q && item_q.player_busy;
		dispatch   = (item_q.op == OP_TICK) && !still_busy && (count_q != '0);
		wen            = 1'b0;
		widx           = best_idx_q;
		wdata          = last_q;
		status         = PS_NONE;
		pv             = 1'b0;
		pclip          = '0;
		count_d        = count_q;
		next_order_d   = next_order_q;
		playing_d      = playing_q;
		playing_clip_d = playing_clip_q;
		full_drops_d   = full_drops_q;
		dup_drops_d    = dup_drops_q;
		if (item_q.op == OP_PUSH) begin
			if (dup_hit) begin
				status      = PS_DUP;
				dup_drops_d = dup_drops_q + CTR_W'(1);
			end else if (is_full) begin
				status       = PS_FULL;
				full_drops_d = full_drops_q + CTR_W'(1);
			end else begin
				status       = PS_ACCEPT;
				wen          = (state_q == ST_FIN);
				widx         = count_q[IDX_W-1:0];
				wdata.clip   = item_q.clip_id;
				wdata.level  = LEVEL_BITS'(item_q.level);
				wdata.order  = next_order_q;
				next_order_d = next_order_q + ORDER_W'(1);
				count_d      = count_q + CNT_W'(1);
			end
		end else begin
			playing_d = still_busy;
			if (dispatch) begin
				wen            = (state_q == ST_FIN);
				pv             = 1'b1;
				pclip          = best_q.clip;
				playing_d      = 1'b1;
				playing_clip_d = best_q.clip;
				count_d        = count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			next_order_q   <= '0;
			playing_q      <= 1'b0;
			playing_clip_q <= '0;
			full_drops_q   <= '0;
			dup_drops_q    <= '0;
			done_q         <= 1'b0;
		end else begin
			done_q <= (state_q == ST_FIN);
			if (state_q == ST_FIN) begin
				count_q        <= count_d;
				next_order_q   <= next_order_d;
				playing_q      <= playing_d;
				playing_clip_q <= playing_clip_d;
				full_drops_q   <= full_drops_d;
				dup_drops_q    <= dup_drops_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN) begin
			result_q.play_valid  <= pv;
			result_q.play_clip   <= pclip;
			result_q.push_status <= status;
			result_q.queue_level <= 5'(count_d);
			result_q.playing     <= playing_d;
			result_q.full_drops  <= full_drops_d;
			result_q.dup_drops   <= dup_drops_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`PDQ_ASSERT_ALWAYS(a_count_cap, clk, arst_n, count_q <= CNT_W'(CAPACITY), "queue count above capacity")
	`PDQ_ASSERT_IMPLY(a_done_idle, clk, arst_n, done, !busy, "result strobe while busy")
	`PDQ_ASSERT_NEXT(a_accept_scan, clk, arst_n, start && !busy, (state_q == ST_SCAN) && (cnt_q == '0), "accepted word did not start a scan")
	`PDQ_ASSERT_IMPLY(a_dispatch_playing, clk, arst_n, done && result.play_valid, result.playing && (result.push_status == PS_NONE), "dispatch without playing tick")

endmodule
